>>> rtl/rppd_pkg.sv
`default_nettype none

package rppd_pkg;

  // Table geometry
  localparam int NumEntries    = 8;
  localparam int EntryW        = 3;
  localparam int IdxW          = 4;
  localparam int WordsPerEntry = 14;
  localparam int WordW         = 4;
  localparam int DurW          = 16;
  localparam int MsgBits       = 32;
  localparam int CntW          = 8;
  localparam int TimeW         = 32;
  localparam int InDataW       = 56;
  localparam int OutDataW      = 56;

  // Request kinds
  localparam logic [1:0] REQ_EDGE   = 2'd0;
  localparam logic [1:0] REQ_TWRITE = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_MINBITS = 2'd1;
  localparam logic [1:0] CFG_ENTRIES = 2'd2;

  // Reported state codes
  localparam logic [1:0] SC_SEEK = 2'd0;
  localparam logic [1:0] SC_DATA = 2'd1;
  localparam logic [1:0] SC_MSG  = 2'd2;

  // Pulse pair classes
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_ZERO = 2'd1;
  localparam logic [1:0] CLS_ONE  = 2'd2;

  // Table word slots
  localparam logic [WordW-1:0] W_PROTO = 4'd0;
  localparam logic [WordW-1:0] W_INV   = 4'd1;
  localparam logic [WordW-1:0] W_SA_LO = 4'd2;
  localparam logic [WordW-1:0] W_SA_HI = 4'd3;
  localparam logic [WordW-1:0] W_SB_LO = 4'd4;
  localparam logic [WordW-1:0] W_SB_HI = 4'd5;
  localparam logic [WordW-1:0] W_0A_LO = 4'd6;
  localparam logic [WordW-1:0] W_0A_HI = 4'd7;
  localparam logic [WordW-1:0] W_0B_LO = 4'd8;
  localparam logic [WordW-1:0] W_0B_HI = 4'd9;
  localparam logic [WordW-1:0] W_1A_LO = 4'd10;
  localparam logic [WordW-1:0] W_1A_HI = 4'd11;
  localparam logic [WordW-1:0] W_1B_LO = 4'd12;
  localparam logic [WordW-1:0] W_1B_HI = 4'd13;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EDGE,
    CMD_TWRITE,
    CMD_CLEAR,
    CMD_RD,
    CMD_COL_EVAL,
    CMD_AN_EVAL,
    CMD_APPLY,
    CMD_OUT
  } rppd_cmd_e;

  typedef struct packed {
    rppd_cmd_e op;
  } rppd_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       path_collect;
    logic       path_analyze;
    logic       col_end;
    logic       col_stop;
    logic       an_stop;
    logic       apply_restart;
    logic       lvl_diff;
    logic       out_free;
  } rppd_stat_t;

endpackage

`default_nettype wire

>>> rtl/rppd_datapath.sv
`default_nettype none

module rppd_datapath
  import rppd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rppd_cmd_t           cmd_i,
  output rppd_stat_t               stat_o,
  input  wire logic [1:0]          s_tuser_i,
  input  wire logic [InDataW-1:0]  s_tdata_i,
  input  wire logic                cfg_valid_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [7:0]          cfg_data_i,
  input  wire logic                m_tready_i,
  output logic                     m_tvalid_o,
  output logic [OutDataW-1:0]      m_tdata_o,
  output logic [1:0]               m_tuser_o
);

  // Request word
  logic [1:0]       req_q;
  logic             level_q;
  logic [TimeW-1:0] time_q;
  logic [EntryW-1:0] entry_q;
  logic [WordW-1:0] word_q;
  logic [DurW-1:0]  value_q;

  // Configuration
  logic             en_q;
  logic [CntW-1:0]  min_q;
  logic [3:0]       ent_q;

  // Receiver state
  logic [TimeW-1:0] last_q;
  logic [DurW-1:0]  dur_q [2];
  logic             low_q [2];
  logic [1:0]       held_q;
  logic [NumEntries-1:0] mask_q;
  logic             phase_q;
  logic [MsgBits-1:0] store_q;
  logic [CntW-1:0]  bits_q;
  logic             latched_q;
  logic [IdxW-1:0]  idx_q;
  logic [1:0]       res_q;
  logic             sync_q;

  // Timing table and its registered row
  logic [DurW-1:0]  tbl_q [NumEntries][WordsPerEntry];
  logic [DurW-1:0]  row_q [WordsPerEntry];
  logic [7:0]       proto_q [NumEntries];

  // Output register
  logic             ovalid_q;
  logic [OutDataW-1:0] odata_q;
  logic [1:0]       ouser_q;

  logic [IdxW-1:0]  n_used;
  logic [TimeW-1:0] delta;
  logic [DurW-1:0]  dur_new;
  logic [DurW-1:0]  ad, bd;
  logic [EntryW-1:0] cur;
  logic             c_lvl, c_break, c_hit;
  logic             a_sync, a_ok;
  logic [1:0]       ca, cb;
  logic [CntW-1:0]  stored;
  logic             accept_msg;
  logic [7:0]       proto_sel;

  assign n_used  = (ent_q > IdxW'(NumEntries)) ? IdxW'(NumEntries) : ent_q;
  assign delta   = time_q - last_q;
  assign dur_new = (|delta[TimeW-1:DurW]) ? {DurW{1'b1}} : delta[DurW-1:0];
  assign ad      = dur_q[0];
  assign bd      = dur_q[1];
  assign cur     = idx_q[EntryW-1:0];

  // Sync window test while seeking
  assign c_lvl   = ((row_q[W_INV] != '0) == low_q[0]);
  assign c_break = c_lvl && (ad < row_q[W_SA_LO]);
  assign c_hit   = c_lvl && !c_break && (ad < row_q[W_SA_HI])
                   && (bd >= row_q[W_SB_LO]) && (bd < row_q[W_SB_HI]);

  // Pair classification for one candidate
  assign a_sync = mask_q[cur] && (ad >= row_q[W_SA_LO])
                  && (bd >= row_q[W_SB_LO]) && (bd < row_q[W_SB_HI]);

  always_comb begin
    if (ad >= row_q[W_0A_LO] && ad < row_q[W_0A_HI]) begin
      ca = CLS_ZERO;
    end else if (ad >= row_q[W_1A_LO] && ad < row_q[W_1A_HI]) begin
      ca = CLS_ONE;
    end else begin
      ca = CLS_NONE;
    end
    if (bd >= row_q[W_0B_LO] && bd < row_q[W_0B_HI]) begin
      cb = CLS_ZERO;
    end else if (bd >= row_q[W_1B_LO] && bd < row_q[W_1B_HI]) begin
      cb = CLS_ONE;
    end else begin
      cb = CLS_NONE;
    end
  end

  assign a_ok       = (ca == cb) && (cb != CLS_NONE);
  assign stored     = (bits_q > CntW'(MsgBits)) ? CntW'(MsgBits) : bits_q;
  assign accept_msg = sync_q && (stored >= min_q);

  // Lowest candidate wins
  always_comb begin
    proto_sel = '0;
    for (int i = NumEntries - 1; i >= 0; i--) begin
      if (mask_q[i]) proto_sel = proto_q[i];
    end
  end

  // Status to controller
  always_comb begin
    stat_o.req_type      = req_q;
    stat_o.path_collect  = en_q && !latched_q && (mask_q == '0)
                           && (held_q != 2'd0) && (level_q != low_q[1]);
    stat_o.path_analyze  = en_q && !latched_q && (mask_q != '0) && phase_q;
    stat_o.col_end       = (idx_q >= n_used);
    stat_o.col_stop      = c_break;
    stat_o.an_stop       = a_sync || (idx_q == '0);
    stat_o.apply_restart = sync_q ? !accept_msg : (res_q == CLS_NONE);
    stat_o.lvl_diff      = (low_q[0] != low_q[1]);
    stat_o.out_free      = !ovalid_q || m_tready_i;
  end

  // Request latch and table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_LOAD) begin
      req_q   <= s_tuser_i;
      level_q <= s_tdata_i[0];
      time_q  <= s_tdata_i[32:1];
      entry_q <= s_tdata_i[35:33];
      word_q  <= s_tdata_i[39:36];
      value_q <= s_tdata_i[55:40];
    end
    if (cmd_i.op == CMD_TWRITE && word_q < WordW'(WordsPerEntry)) begin
      tbl_q[entry_q][word_q] <= value_q;
      if (word_q == W_PROTO) proto_q[entry_q] <= value_q[7:0];
    end
    if (cmd_i.op == CMD_RD) begin
      row_q <= tbl_q[cur];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b1;
      min_q <= 8'd8;
      ent_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ENABLE:  en_q  <= cfg_data_i[0];
        CFG_MINBITS: min_q <= cfg_data_i;
        CFG_ENTRIES: ent_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Receiver state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      dur_q[0]  <= '0;
      dur_q[1]  <= '0;
      low_q[0]  <= 1'b0;
      low_q[1]  <= 1'b0;
      held_q    <= '0;
      mask_q    <= '0;
      phase_q   <= 1'b0;
      store_q   <= '0;
      bits_q    <= '0;
      latched_q <= 1'b0;
      idx_q     <= '0;
      res_q     <= CLS_NONE;
      sync_q    <= 1'b0;
    end else begin
      case (cmd_i.op)
        CMD_EDGE: begin
          last_q <= time_q;
          if (en_q) begin
            dur_q[0] <= dur_q[1];
            low_q[0] <= low_q[1];
            dur_q[1] <= dur_new;
            low_q[1] <= level_q;
            if (held_q < 2'd2) held_q <= held_q + 2'd1;
            if (!latched_q && mask_q != '0) phase_q <= !phase_q;
          end
          idx_q  <= stat_o.path_analyze ? IdxW'(NumEntries - 1) : '0;
          res_q  <= CLS_NONE;
          sync_q <= 1'b0;
        end
        CMD_CLEAR: begin
          mask_q    <= '0;
          store_q   <= '0;
          bits_q    <= '0;
          held_q    <= '0;
          phase_q   <= 1'b0;
          latched_q <= 1'b0;
        end
        CMD_COL_EVAL: begin
          if (c_hit) mask_q[cur] <= 1'b1;
          idx_q <= idx_q + 1'b1;
        end
        CMD_AN_EVAL: begin
          if (a_sync) begin
            sync_q <= 1'b1;
          end else if (mask_q[cur]) begin
            if (a_ok) begin
              if (res_q == CLS_NONE) res_q <= cb;
            end else begin
              mask_q[cur] <= 1'b0;
            end
          end
          if (!stat_o.an_stop) idx_q <= idx_q - 1'b1;
        end
        CMD_APPLY: begin
          if (accept_msg) begin
            latched_q <= 1'b1;
          end else if (stat_o.apply_restart) begin
            mask_q  <= '0;
            store_q <= '0;
            bits_q  <= '0;
            held_q  <= '0;
            idx_q   <= '0;
          end else begin
            if (bits_q < CntW'(MsgBits)) store_q <= {store_q[MsgBits-2:0], res_q == CLS_ONE};
            if (bits_q != {CntW{1'b1}}) bits_q <= bits_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.op == CMD_OUT) begin
      ovalid_q <= 1'b1;
    end else if (m_tready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_OUT) begin
      ouser_q <= latched_q ? SC_MSG : ((mask_q != '0) ? SC_DATA : SC_SEEK);
      odata_q <= {6'b0, (mask_q != '0), proto_sel,
                  latched_q ? bits_q : '0,
                  latched_q ? store_q : '0,
                  latched_q};
    end
  end

  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o  = odata_q;
  assign m_tuser_o  = ouser_q;

endmodule

`default_nettype wire

>>> rtl/rppd_ctrl.sv
`default_nettype none

module rppd_ctrl
  import rppd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_tvalid_i,
  output logic            s_tready_o,
  input  wire rppd_stat_t stat_i,
  output rppd_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_COL_RD,
    S_COL_EV,
    S_AN_RD,
    S_AN_EV,
    S_APPLY,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   ready_q;

  // Issue one datapath command per state
  always_comb begin
    cmd_o.op = CMD_NONE;
    case (state_q)
      S_IDLE:   if (s_tvalid_i) cmd_o.op = CMD_LOAD;
      S_EXEC: begin
        case (stat_i.req_type)
          REQ_EDGE:   cmd_o.op = CMD_EDGE;
          REQ_TWRITE: cmd_o.op = CMD_TWRITE;
          REQ_CLEAR:  cmd_o.op = CMD_CLEAR;
          default:    cmd_o.op = CMD_NONE;
        endcase
      end
      S_COL_RD: if (!stat_i.col_end) cmd_o.op = CMD_RD;
      S_COL_EV: cmd_o.op = CMD_COL_EVAL;
      S_AN_RD:  cmd_o.op = CMD_RD;
      S_AN_EV:  cmd_o.op = CMD_AN_EVAL;
      S_APPLY:  cmd_o.op = CMD_APPLY;
      S_FINISH: if (stat_i.out_free) cmd_o.op = CMD_OUT;
      default:  cmd_o.op = CMD_NONE;
    endcase
  end

  // Sequence the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_tvalid_i) begin
            state_q <= S_EXEC;
            ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          if (stat_i.req_type == REQ_EDGE && stat_i.path_collect) begin
            state_q <= S_COL_RD;
          end else if (stat_i.req_type == REQ_EDGE && stat_i.path_analyze) begin
            state_q <= S_AN_RD;
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_COL_RD: state_q <= stat_i.col_end ? S_FINISH : S_COL_EV;
        S_COL_EV: state_q <= stat_i.col_stop ? S_FINISH : S_COL_RD;
        S_AN_RD:  state_q <= S_AN_EV;
        S_AN_EV:  state_q <= stat_i.an_stop ? S_APPLY : S_AN_RD;
        S_APPLY: begin
          state_q <= (stat_i.apply_restart && stat_i.lvl_diff) ? S_COL_RD : S_FINISH;
        end
        S_FINISH: begin
          if (stat_i.out_free) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_tready_o = ready_q;

endmodule

`default_nettype wire

>>> rtl/rc_pulse_pair_decoder.sv
// Channel   Dir  Handshake          Contents
// s_axis    in   tvalid/tready      tuser req_type; tdata pin, time, entry, word, value
// m_axis    out  tvalid/tready      tuser state_code; tdata ready, bits, count, protocol
// cfg       in   cfg_valid/ready    cfg_index register, cfg_data value
//
// A table write, clear or disabled edge goes from the execute state straight to
// the finish state; the next word is taken once its result is registered.
// Edges that scan the timing table take a read state and an evaluate state per
// entry through the single registered table row; analysis that restarts
// collection scans the table again from the first entry.
// Reset clears all receiver state; table contents are undefined until written.
// A stalled result holds in the output register; the next word is taken
// meanwhile and waits for that register before presenting its result.
`default_nettype none

module rc_pulse_pair_decoder
  import rppd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // pin_level, edge_time_us, table_entry,
                                                  // table_word, table_value
  input  wire logic [1:0]          s_axis_tuser,  // req_type
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,  // message_ready, received_bits, bit_count,
                                                  // protocol_number, protocol_found
  output logic [1:0]               m_axis_tuser,  // state_code
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [7:0]          cfg_data_i
);

  rppd_cmd_t  cmd;
  rppd_stat_t stat;

  assign cfg_ready_o = 1'b1;

  rppd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rppd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .s_tuser_i   (s_axis_tuser),
    .s_tdata_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> rtl/rppd_checker.sv
`default_nettype none

module rppd_checker
  import rppd_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,
  input wire logic [1:0]          m_axis_tuser
);

  // Message flag agrees with the reported state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tuser == SC_MSG)))
    else $error("message flag and state disagree");

  // Without a message, bits and count read zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[40:1] == '0))
    else $error("bits shown without a message");

  // No candidate means no protocol number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[49]) |-> (m_axis_tdata[48:41] == '0))
    else $error("protocol number without candidate");

  // Stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind rc_pulse_pair_decoder rppd_checker u_rppd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
